[src/rdm_pkg.sv]
// Shared types, constants and index tables for the reduced density matrix accumulator.
package rdm_pkg;

  localparam int AMP_WIDTH_DEF  = 16;
  localparam int MAX_QUBITS_DEF = 40;
  localparam int ACC_WIDTH_DEF  = 48;

  localparam int COUNT_W     = 40;
  localparam int QUBIT_W     = 6;
  localparam int REG_ADDR_W  = 4;
  localparam int ENTRY_COUNT = 10;
  localparam int ENTRY_IDX_W = $clog2(ENTRY_COUNT);

  localparam logic [1:0] REG_PAIR_MODE    = 2'd0;
  localparam logic [1:0] REG_QUBIT_FIRST  = 2'd1;
  localparam logic [1:0] REG_QUBIT_SECOND = 2'd2;
  localparam logic [1:0] REG_QUBIT_TOTAL  = 2'd3;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_COUNT = 2'd1,
    STATUS_RANGE = 2'd2,
    STATUS_SAME  = 2'd3
  } status_t;

  typedef struct packed {
    logic    wr;
    logic    pair;
    status_t status;
  } snap_t;

  // Upper-triangle storage slot for each matrix position, row order.
  localparam logic [ENTRY_IDX_W-1:0] TRI_INDEX [4][4] = '{
    '{4'd0, 4'd1, 4'd2, 4'd3},
    '{4'd1, 4'd4, 4'd5, 4'd6},
    '{4'd2, 4'd5, 4'd7, 4'd8},
    '{4'd3, 4'd6, 4'd8, 4'd9}
  };
  localparam logic [1:0] TRI_ROW [ENTRY_COUNT] = '{
    2'd0, 2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd1, 2'd2, 2'd2, 2'd3
  };
  localparam logic [1:0] TRI_COL [ENTRY_COUNT] = '{
    2'd0, 2'd1, 2'd2, 2'd3, 2'd1, 2'd2, 2'd3, 2'd2, 2'd3, 2'd3
  };

  // Slots that belong to the 2x2 matrix.
  function automatic logic single_entry(input logic [ENTRY_IDX_W-1:0] t);
    return t inside {4'd0, 4'd1, 4'd4};
  endfunction

endpackage

[src/rdm_readout.sv]
// Matrix snapshot bank and row-by-row result sequencer with Q1.30 conversion.
module rdm_readout #(
  parameter int AMP_WIDTH = rdm_pkg::AMP_WIDTH_DEF,
  parameter int ACC_WIDTH = rdm_pkg::ACC_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rdm_pkg::snap_t       snap,
  input  logic [ACC_WIDTH-1:0] snap_re [rdm_pkg::ENTRY_COUNT],
  input  logic [ACC_WIDTH-1:0] snap_im [rdm_pkg::ENTRY_COUNT],
  output logic                 busy,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_row_index,
  output logic [1:0]           out_col_index,
  output logic signed [31:0]   out_entry_real,
  output logic signed [31:0]   out_entry_imag,
  output logic [1:0]           out_status,
  output logic                 out_result_last
);
  import rdm_pkg::*;

  localparam int SHIFT = 2 * AMP_WIDTH - 32;
  localparam int SHL   = (SHIFT < 0) ? -SHIFT : 0;
  localparam int SHR   = (SHIFT > 0) ? SHIFT : 0;
  localparam int WIDE  = ACC_WIDTH + 1 + SHL;

  logic [ACC_WIDTH-1:0] bank_re_r [ENTRY_COUNT];
  logic [ACC_WIDTH-1:0] bank_im_r [ENTRY_COUNT];

  logic       busy_r;
  logic       pair_r;
  status_t    status_r;
  logic [1:0] row_r;
  logic [1:0] col_r;

  logic              out_valid_r;
  logic [1:0]        out_row_r;
  logic [1:0]        out_col_r;
  logic [31:0]       out_re_r;
  logic [31:0]       out_im_r;
  status_t           out_status_r;
  logic              out_last_r;

  logic                   load;
  logic                   err;
  logic                   last_entry;
  logic [1:0]             dim_max;
  logic [ENTRY_IDX_W-1:0] slot;
  logic signed [WIDE-1:0] re_ext;
  logic signed [WIDE-1:0] im_base;
  logic signed [WIDE-1:0] im_ext;

  // Align to 30 fraction bits, then saturate to 32 bits.
  function automatic logic [31:0] to_q30(input logic signed [WIDE-1:0] v);
    logic signed [WIDE-1:0] sh;
    logic [WIDE-32:0]       top;
    sh  = (v <<< SHL) >>> SHR;
    top = sh[WIDE-1:31];
    if ((&top) || !(|top)) begin
      return sh[31:0];
    end
    return {sh[WIDE-1], {31{~sh[WIDE-1]}}};
  endfunction

  assign dim_max    = pair_r ? 2'd3 : 2'd1;
  assign err        = (status_r != STATUS_OK);
  assign last_entry = (row_r == dim_max) && (col_r == dim_max);
  assign load       = busy_r && (!out_valid_r || out_ready);
  assign slot       = TRI_INDEX[row_r][col_r];

  always_comb begin
    re_ext  = {{(WIDE - ACC_WIDTH){bank_re_r[slot][ACC_WIDTH-1]}}, bank_re_r[slot]};
    im_base = {{(WIDE - ACC_WIDTH){bank_im_r[slot][ACC_WIDTH-1]}}, bank_im_r[slot]};
    im_ext  = (col_r < row_r) ? -im_base : im_base;
  end

  always_ff @(posedge clk) begin
    if (snap.wr) begin
      bank_re_r <= snap_re;
      bank_im_r <= snap_im;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      pair_r   <= 1'b0;
      status_r <= STATUS_OK;
      row_r    <= 2'd0;
      col_r    <= 2'd0;
    end else if (snap.wr) begin
      busy_r   <= 1'b1;
      pair_r   <= snap.pair;
      status_r <= snap.status;
      row_r    <= 2'd0;
      col_r    <= 2'd0;
    end else if (load) begin
      if (err || last_entry) begin
        busy_r <= 1'b0;
      end else if (col_r == dim_max) begin
        col_r <= 2'd0;
        row_r <= row_r + 2'd1;
      end else begin
        col_r <= col_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (err) begin
        out_row_r    <= 2'd0;
        out_col_r    <= 2'd0;
        out_re_r     <= 32'd0;
        out_im_r     <= 32'd0;
        out_status_r <= status_r;
        out_last_r   <= 1'b1;
      end else begin
        out_row_r    <= row_r;
        out_col_r    <= col_r;
        out_re_r     <= to_q30(re_ext);
        out_im_r     <= to_q30(im_ext);
        out_status_r <= STATUS_OK;
        out_last_r   <= last_entry;
      end
    end
  end

  assign busy            = busy_r;
  assign out_valid       = out_valid_r;
  assign out_row_index   = out_row_r;
  assign out_col_index   = out_col_r;
  assign out_entry_real  = out_re_r;
  assign out_entry_imag  = out_im_r;
  assign out_status      = out_status_r;
  assign out_result_last = out_last_r;

`ifndef ASSERT_OFF
  a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r != STATUS_OK) |-> out_last_r)
    else $error("error result not marked last");
  a_busy_ends_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy_r) |-> out_valid_r && out_last_r)
    else $error("sequencer stopped before the final result");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    snap.wr |-> !busy_r)
    else $error("snapshot written while a matrix is still being sent");
`endif

endmodule

[src/reduced_density_matrix_accumulator_top.sv]
// Top level of the reduced density matrix accumulator: registers, pipeline and accumulators.
//
//   channel  direction  handshake          payload
//   in       request    in_valid/in_ready  four complex amplitudes and group_last
//   out      result     out_valid/out_ready entry position, value, status, result_last
//   cfg      write/read psel/penable/pready four registers at byte offsets 0, 4, 8, 12
//
// One amplitude group is taken every cycle while the pipeline does not stall; it passes an
// input register and a product register before it reaches the accumulators. A matrix is
// sent one entry per cycle while out_ready is high (16, 4, or a single error result), set
// by the readout sequencer; a final group waits in the product stage while the previous
// matrix is still being sent. Reset clears the accumulators and group count at once.
module reduced_density_matrix_accumulator_top #(
  parameter int AMP_WIDTH  = rdm_pkg::AMP_WIDTH_DEF,
  parameter int MAX_QUBITS = rdm_pkg::MAX_QUBITS_DEF,
  parameter int ACC_WIDTH  = rdm_pkg::ACC_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rdm_pkg::REG_ADDR_W-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [AMP_WIDTH-1:0]   in_amp0_real,
  input  logic signed [AMP_WIDTH-1:0]   in_amp0_imag,
  input  logic signed [AMP_WIDTH-1:0]   in_amp1_real,
  input  logic signed [AMP_WIDTH-1:0]   in_amp1_imag,
  input  logic signed [AMP_WIDTH-1:0]   in_amp2_real,
  input  logic signed [AMP_WIDTH-1:0]   in_amp2_imag,
  input  logic signed [AMP_WIDTH-1:0]   in_amp3_real,
  input  logic signed [AMP_WIDTH-1:0]   in_amp3_imag,
  input  logic                          in_group_last,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_row_index,
  output logic [1:0]                    out_col_index,
  output logic signed [31:0]            out_entry_real,
  output logic signed [31:0]            out_entry_imag,
  output logic [1:0]                    out_status,
  output logic                          out_result_last
);
  import rdm_pkg::*;

  localparam int PROD_W = 2 * AMP_WIDTH;
  localparam int PSUM_W = PROD_W + 1;
  localparam int PW     = (PSUM_W > 64) ? 64 : PSUM_W;
  localparam int SUM_W  = ((ACC_WIDTH > PW) ? ACC_WIDTH : PW) + 1;

  // Configuration registers.
  logic               pair_mode_r;
  logic [QUBIT_W-1:0] qubit_first_r;
  logic [QUBIT_W-1:0] qubit_second_r;
  logic [QUBIT_W-1:0] qubit_total_r;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pair_mode_r    <= 1'b1;
      qubit_first_r  <= 6'd0;
      qubit_second_r <= 6'd1;
      qubit_total_r  <= 6'd2;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_PAIR_MODE:    pair_mode_r    <= pwdata[0];
        REG_QUBIT_FIRST:  qubit_first_r  <= pwdata[QUBIT_W-1:0];
        REG_QUBIT_SECOND: qubit_second_r <= pwdata[QUBIT_W-1:0];
        REG_QUBIT_TOTAL:  qubit_total_r  <= pwdata[QUBIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_PAIR_MODE:    prdata = {31'd0, pair_mode_r};
      REG_QUBIT_FIRST:  prdata = {{(32 - QUBIT_W){1'b0}}, qubit_first_r};
      REG_QUBIT_SECOND: prdata = {{(32 - QUBIT_W){1'b0}}, qubit_second_r};
      REG_QUBIT_TOTAL:  prdata = {{(32 - QUBIT_W){1'b0}}, qubit_total_r};
      default:          prdata = 32'd0;
    endcase
  end

  // Pipeline control.
  logic s1_valid_r, s1_last_r;
  logic s2_valid_r, s2_last_r;
  logic s1_adv, s1_free, s2_adv, s2_free;
  logic busy;

  assign s2_adv   = s2_valid_r && !(s2_last_r && busy);
  assign s2_free  = !s2_valid_r || s2_adv;
  assign s1_adv   = s1_valid_r && s2_free;
  assign s1_free  = !s1_valid_r || s1_adv;
  assign in_ready = s1_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid_r <= in_valid;
      end
      if (s2_free) begin
        s2_valid_r <= s1_valid_r;
      end
    end
  end

  // Input register.
  logic signed [AMP_WIDTH-1:0] amp_re_r [4];
  logic signed [AMP_WIDTH-1:0] amp_im_r [4];

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      amp_re_r[0] <= in_amp0_real;
      amp_im_r[0] <= in_amp0_imag;
      amp_re_r[1] <= in_amp1_real;
      amp_im_r[1] <= in_amp1_imag;
      amp_re_r[2] <= in_amp2_real;
      amp_im_r[2] <= in_amp2_imag;
      amp_re_r[3] <= in_amp3_real;
      amp_im_r[3] <= in_amp3_imag;
      s1_last_r   <= in_group_last;
    end
  end

  // Outer-product terms of the upper triangle.
  logic [PW-1:0] prod_re_nxt [ENTRY_COUNT];
  logic [PW-1:0] prod_im_nxt [ENTRY_COUNT];
  logic [PW-1:0] prod_re_r   [ENTRY_COUNT];
  logic [PW-1:0] prod_im_r   [ENTRY_COUNT];

  always_comb begin
    logic signed [PROD_W-1:0] p_rr, p_ii, p_ir, p_ri;
    logic [PSUM_W-1:0]        s_re, s_im;
    logic [PSUM_W-PW:0]       top_re, top_im;
    for (int t = 0; t < ENTRY_COUNT; t++) begin
      p_rr   = amp_re_r[TRI_ROW[t]] * amp_re_r[TRI_COL[t]];
      p_ii   = amp_im_r[TRI_ROW[t]] * amp_im_r[TRI_COL[t]];
      p_ir   = amp_im_r[TRI_ROW[t]] * amp_re_r[TRI_COL[t]];
      p_ri   = amp_re_r[TRI_ROW[t]] * amp_im_r[TRI_COL[t]];
      s_re   = {p_rr[PROD_W-1], p_rr} + {p_ii[PROD_W-1], p_ii};
      s_im   = {p_ir[PROD_W-1], p_ir} - {p_ri[PROD_W-1], p_ri};
      top_re = s_re[PSUM_W-1:PW-1];
      top_im = s_im[PSUM_W-1:PW-1];
      prod_re_nxt[t] = ((&top_re) || !(|top_re)) ? s_re[PW-1:0]
                       : {s_re[PSUM_W-1], {(PW - 1){~s_re[PSUM_W-1]}}};
      prod_im_nxt[t] = ((&top_im) || !(|top_im)) ? s_im[PW-1:0]
                       : {s_im[PSUM_W-1], {(PW - 1){~s_im[PSUM_W-1]}}};
      if (!pair_mode_r && !single_entry(ENTRY_IDX_W'(t))) begin
        prod_re_nxt[t] = '0;
        prod_im_nxt[t] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      prod_re_r <= prod_re_nxt;
      prod_im_r <= prod_im_nxt;
      s2_last_r <= s1_last_r;
    end
  end

  // Saturating accumulation and group count.
  logic [ACC_WIDTH-1:0] acc_re_r   [ENTRY_COUNT];
  logic [ACC_WIDTH-1:0] acc_im_r   [ENTRY_COUNT];
  logic [ACC_WIDTH-1:0] acc_re_nxt [ENTRY_COUNT];
  logic [ACC_WIDTH-1:0] acc_im_nxt [ENTRY_COUNT];
  logic [COUNT_W-1:0]   group_count_r;
  logic [COUNT_W-1:0]   count_inc;

  always_comb begin
    logic [SUM_W-1:0]           a_re, a_im;
    logic [SUM_W-ACC_WIDTH:0]   top_re, top_im;
    for (int t = 0; t < ENTRY_COUNT; t++) begin
      a_re = {{(SUM_W - ACC_WIDTH){acc_re_r[t][ACC_WIDTH-1]}}, acc_re_r[t]}
           + {{(SUM_W - PW){prod_re_r[t][PW-1]}}, prod_re_r[t]};
      a_im = {{(SUM_W - ACC_WIDTH){acc_im_r[t][ACC_WIDTH-1]}}, acc_im_r[t]}
           + {{(SUM_W - PW){prod_im_r[t][PW-1]}}, prod_im_r[t]};
      top_re = a_re[SUM_W-1:ACC_WIDTH-1];
      top_im = a_im[SUM_W-1:ACC_WIDTH-1];
      acc_re_nxt[t] = ((&top_re) || !(|top_re)) ? a_re[ACC_WIDTH-1:0]
                      : {a_re[SUM_W-1], {(ACC_WIDTH - 1){~a_re[SUM_W-1]}}};
      acc_im_nxt[t] = ((&top_im) || !(|top_im)) ? a_im[ACC_WIDTH-1:0]
                      : {a_im[SUM_W-1], {(ACC_WIDTH - 1){~a_im[SUM_W-1]}}};
    end
  end

  assign count_inc = (&group_count_r) ? group_count_r : group_count_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int t = 0; t < ENTRY_COUNT; t++) begin
        acc_re_r[t] <= '0;
        acc_im_r[t] <= '0;
      end
      group_count_r <= '0;
    end else if (s2_adv) begin
      if (s2_last_r) begin
        for (int t = 0; t < ENTRY_COUNT; t++) begin
          acc_re_r[t] <= '0;
          acc_im_r[t] <= '0;
        end
        group_count_r <= '0;
      end else begin
        acc_re_r      <= acc_re_nxt;
        acc_im_r      <= acc_im_nxt;
        group_count_r <= count_inc;
      end
    end
  end

  // Checks on the final group.
  status_t            status;
  logic [QUBIT_W-1:0] exp_shift;
  logic [COUNT_W-1:0] expected;

  always_comb begin
    status    = STATUS_OK;
    exp_shift = qubit_total_r - (pair_mode_r ? 6'd2 : 6'd1);
    expected  = {{(COUNT_W - 1){1'b0}}, 1'b1} << exp_shift;
    if ((qubit_total_r == '0) || (qubit_total_r > QUBIT_W'(MAX_QUBITS))) begin
      status = STATUS_COUNT;
    end else if (!(pair_mode_r && (qubit_total_r == 6'd1)) && (count_inc != expected)) begin
      status = STATUS_COUNT;
    end
    if (status == STATUS_OK) begin
      if ((qubit_first_r >= qubit_total_r)
          || (pair_mode_r && (qubit_second_r >= qubit_total_r))) begin
        status = STATUS_RANGE;
      end else if (pair_mode_r && (qubit_first_r == qubit_second_r)) begin
        status = STATUS_SAME;
      end
    end
  end

  snap_t snap;

  assign snap.wr     = s2_adv && s2_last_r;
  assign snap.pair   = pair_mode_r;
  assign snap.status = status;

  rdm_readout #(
    .AMP_WIDTH (AMP_WIDTH),
    .ACC_WIDTH (ACC_WIDTH)
  ) u_readout (
    .clk             (clk),
    .rst_n           (rst_n),
    .snap            (snap),
    .snap_re         (acc_re_nxt),
    .snap_im         (acc_im_nxt),
    .busy            (busy),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_row_index   (out_row_index),
    .out_col_index   (out_col_index),
    .out_entry_real  (out_entry_real),
    .out_entry_imag  (out_entry_imag),
    .out_status      (out_status),
    .out_result_last (out_result_last)
  );

`ifndef ASSERT_OFF
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    s2_adv && s2_last_r |=> group_count_r == '0)
    else $error("group count not cleared after the final group");
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s2_valid_r && !s2_adv |-> !in_ready)
    else $error("request accepted while the pipeline is full");
  a_stall_only_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r && !s2_adv |=> s2_valid_r && s2_last_r)
    else $error("product stage lost a stalled final group");
`endif

endmodule

[tb/tb.sv]
// Self-checking testbench for the reduced density matrix accumulator top level.
module tb;
  import rdm_pkg::*;

  localparam int AW = AMP_WIDTH_DEF;
  localparam logic signed [AW-1:0] AMP_MIN = {1'b1, {(AW-1){1'b0}}};
  localparam logic signed [AW-1:0] AMP_MAX = {1'b0, {(AW-1){1'b1}}};
  localparam longint ACC_HI = (longint'(1) <<< (ACC_WIDTH_DEF - 1)) - 1;
  localparam longint COUNT_TOP = (longint'(1) << COUNT_W) - 1;
  localparam longint Q30_HI = 64'sd2147483647;

  typedef struct {
    logic [1:0]         row;
    logic [1:0]         col;
    logic signed [31:0] re;
    logic signed [31:0] im;
    status_t            status;
    logic               last;
  } entry_t;

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [REG_ADDR_W-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;
  logic                  in_valid;
  logic                  in_ready;
  logic signed [AW-1:0]  in_amp0_real;
  logic signed [AW-1:0]  in_amp0_imag;
  logic signed [AW-1:0]  in_amp1_real;
  logic signed [AW-1:0]  in_amp1_imag;
  logic signed [AW-1:0]  in_amp2_real;
  logic signed [AW-1:0]  in_amp2_imag;
  logic signed [AW-1:0]  in_amp3_real;
  logic signed [AW-1:0]  in_amp3_imag;
  logic                  in_group_last;
  logic                  out_valid;
  logic                  out_ready;
  logic [1:0]            out_row_index;
  logic [1:0]            out_col_index;
  logic signed [31:0]    out_entry_real;
  logic signed [31:0]    out_entry_imag;
  logic [1:0]            out_status;
  logic                  out_result_last;

  reduced_density_matrix_accumulator_top uut (.*);

  longint               acc_re [10];
  longint               acc_im [10];
  longint               groups_seen;
  logic                 cfg_pair;
  logic [5:0]           cfg_first;
  logic [5:0]           cfg_second;
  logic [5:0]           cfg_total;
  entry_t               pending_entries [$];
  logic signed [AW-1:0] grp_re [4];
  logic signed [AW-1:0] grp_im [4];
  bit                   in_idle;
  bit                   out_idle;
  int                   hold_cycles;
  int                   groups_sent;
  int                   matrices_seen;
  int                   entries_checked;
  int                   mismatches;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (mismatches < 20)
      $display("MISMATCH at %0t: %s, got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  function automatic int slot(input int r, input int c);
    return r * 4 - r * (r - 1) / 2 + (c - r);
  endfunction

  function automatic longint clamp(input longint v, input longint hi);
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  function automatic void clear_accumulators();
    foreach (acc_re[i]) begin
      acc_re[i] = 0;
      acc_im[i] = 0;
    end
    groups_seen = 0;
  endfunction

  // Adds one amplitude group into the predicted accumulators and, on the final
  // group of a state, queues the matrix entries or the error result it produces.
  function automatic void absorb_group(input logic last);
    longint  ar [4];
    longint  ai [4];
    longint  need;
    longint  vi;
    int      dim;
    int      t;
    status_t st;
    entry_t  e;
    dim = cfg_pair ? 4 : 2;
    for (int k = 0; k < 4; k++) begin
      ar[k] = grp_re[k];
      ai[k] = grp_im[k];
    end
    for (int r = 0; r < dim; r++)
      for (int c = r; c < dim; c++) begin
        t = slot(r, c);
        acc_re[t] = clamp(acc_re[t] + (ar[r] * ar[c] + ai[r] * ai[c]), ACC_HI);
        acc_im[t] = clamp(acc_im[t] + (ai[r] * ar[c] - ar[r] * ai[c]), ACC_HI);
      end
    if (groups_seen < COUNT_TOP) groups_seen++;
    if (!last) return;
    matrices_seen++;
    st = STATUS_OK;
    if (cfg_total == 0 || int'(cfg_total) > MAX_QUBITS_DEF) begin
      st = STATUS_COUNT;
    end else if (!(cfg_pair && cfg_total == 1)) begin
      need = longint'(1) << (int'(cfg_total) - (cfg_pair ? 2 : 1));
      if (groups_seen != need) st = STATUS_COUNT;
    end
    if (st == STATUS_OK) begin
      if (cfg_first >= cfg_total || (cfg_pair && cfg_second >= cfg_total)) st = STATUS_RANGE;
      else if (cfg_pair && cfg_first == cfg_second) st = STATUS_SAME;
    end
    if (st != STATUS_OK) begin
      e.row = 2'd0;
      e.col = 2'd0;
      e.re = 32'sd0;
      e.im = 32'sd0;
      e.status = st;
      e.last = 1'b1;
      pending_entries = {pending_entries, e};
    end else begin
      for (int r = 0; r < dim; r++)
        for (int c = 0; c < dim; c++) begin
          t = (r <= c) ? slot(r, c) : slot(c, r);
          vi = (c < r) ? -acc_im[t] : acc_im[t];
          e.row = r[1:0];
          e.col = c[1:0];
          e.re = 32'(clamp(acc_re[t], Q30_HI));
          e.im = 32'(clamp(vi, Q30_HI));
          e.status = STATUS_OK;
          e.last = (r == dim - 1) && (c == dim - 1);
          pending_entries = {pending_entries, e};
        end
    end
    clear_accumulators();
  endfunction

  function automatic logic signed [AW-1:0] draw_amp(input int shift);
    logic signed [AW-1:0] v;
    case ($urandom_range(0, 9))
      0: v = AMP_MIN;
      1: v = AMP_MAX;
      2: v = '0;
      default: begin
        v = AW'($urandom);
        v = v >>> shift;
      end
    endcase
    return v;
  endfunction

  function automatic void fill_group(input int shift);
    for (int k = 0; k < 4; k++) begin
      grp_re[k] = draw_amp(shift);
      grp_im[k] = draw_amp(shift);
    end
  endfunction

  task automatic send_group(input logic last);
    int gap;
    gap = in_idle ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_amp0_real  <= grp_re[0];
    in_amp0_imag  <= grp_im[0];
    in_amp1_real  <= grp_re[1];
    in_amp1_imag  <= grp_im[1];
    in_amp2_real  <= grp_re[2];
    in_amp2_imag  <= grp_im[2];
    in_amp3_real  <= grp_re[3];
    in_amp3_imag  <= grp_im[3];
    in_group_last <= last;
    do @(posedge clk); while (!in_ready);
    absorb_group(last);
    groups_sent++;
  endtask

  task automatic send_state(input int groups, input int shift);
    for (int i = 0; i < groups; i++) begin
      fill_group(shift);
      send_group(i == groups - 1);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_entries.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Writes a register, reads it back and updates the predictor's copy.
  task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
    logic [31:0] want;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_PAIR_MODE:    cfg_pair = value[0];
      REG_QUBIT_FIRST:  cfg_first = value[5:0];
      REG_QUBIT_SECOND: cfg_second = value[5:0];
      REG_QUBIT_TOTAL:  cfg_total = value[5:0];
      default: ;
    endcase
    want = (idx == REG_PAIR_MODE) ? (value & 32'h1) : (value & 32'h3f);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want) report_mismatch("register read-back", prdata, want);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic pair, input logic [5:0] first,
                            input logic [5:0] second, input logic [5:0] total);
    settle();
    write_register(REG_PAIR_MODE, {31'd0, pair});
    write_register(REG_QUBIT_FIRST, {26'd0, first});
    write_register(REG_QUBIT_SECOND, {26'd0, second});
    write_register(REG_QUBIT_TOTAL, {26'd0, total});
  endtask

  always @(posedge clk) begin : check_results
    entry_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_entries.size() == 0) begin
        report_mismatch("result with no request pending", out_row_index, -1);
      end else begin
        want = pending_entries.pop_front();
        if (out_row_index !== want.row) report_mismatch("row_index", out_row_index, want.row);
        if (out_col_index !== want.col) report_mismatch("col_index", out_col_index, want.col);
        if (out_entry_real !== want.re) report_mismatch("entry_real", out_entry_real, want.re);
        if (out_entry_imag !== want.im) report_mismatch("entry_imag", out_entry_imag, want.im);
        if (out_status !== want.status) report_mismatch("status", out_status, want.status);
        if (out_result_last !== want.last)
          report_mismatch("result_last", out_result_last, want.last);
        entries_checked++;
      end
    end
  end

  initial begin : result_receiver
    int stall;
    out_ready = 1'b0;
    stall = 0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) stall = out_idle ? $urandom_range(0, 16) : 0;
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        hold_cycles--;
      end else if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic test_reset_defaults();
    for (int k = 0; k < 4; k++) begin
      grp_re[k] = AMP_MIN;
      grp_im[k] = AMP_MIN;
    end
    send_group(1'b1);
    for (int k = 0; k < 4; k++) begin
      grp_re[k] = k[0] ? AMP_MAX : AMP_MIN;
      grp_im[k] = k[1] ? AMP_MIN : AMP_MAX;
    end
    send_group(1'b1);
    for (int k = 0; k < 4; k++) begin
      grp_re[k] = '0;
      grp_im[k] = '0;
    end
    send_group(1'b1);
  endtask

  task automatic test_single_qubit();
    set_config(1'b0, 6'd0, 6'd63, 6'd1);
    send_state(1, 0);
    set_config(1'b0, 6'd1, 6'd0, 6'd2);
    send_state(2, 0);
  endtask

  task automatic test_status_codes();
    set_config(1'b0, 6'd0, 6'd1, 6'd0);
    send_state(1, 4);
    set_config(1'b1, 6'd0, 6'd1, 6'd63);
    send_state(1, 4);
    set_config(1'b0, 6'd0, 6'd1, 6'd40);
    send_state(2, 4);
    // One group short of the four that three qubits need in single mode.
    set_config(1'b0, 6'd0, 6'd1, 6'd3);
    send_state(3, 4);
    // Pair mode on a one-qubit state skips the group count check.
    set_config(1'b1, 6'd0, 6'd1, 6'd1);
    send_state(2, 4);
    set_config(1'b0, 6'd63, 6'd0, 6'd3);
    send_state(4, 4);
    set_config(1'b1, 6'd2, 6'd2, 6'd3);
    send_state(2, 4);
    set_config(1'b1, 6'd0, 6'd63, 6'd4);
    send_state(4, 4);
  endtask

  task automatic test_output_backpressure();
    set_config(1'b1, 6'd1, 6'd0, 6'd2);
    in_idle = 1'b0;
    out_idle = 1'b0;
    hold_cycles = 300;
    repeat (8) send_state(1, 0);
    settle();
    in_idle = 1'b1;
    out_idle = 1'b1;
  endtask

  task automatic test_random_states(input int stop_at);
    int   total;
    int   need;
    int   groups;
    logic pair;
    logic [5:0] first;
    logic [5:0] second;
    while (groups_sent < stop_at) begin
      pair = 1'($urandom_range(0, 1));
      total = pair ? $urandom_range(2, 6) : $urandom_range(1, 5);
      first = 6'($urandom_range(0, total - 1));
      second = pair ? 6'((first + $urandom_range(1, total - 1)) % total)
                    : 6'($urandom_range(0, 63));
      case ($urandom_range(0, 9))
        0: begin
          case ($urandom_range(0, 3))
            0: total = 0;
            1: total = MAX_QUBITS_DEF;
            2: total = 63;
            default: total = $urandom_range(41, 63);
          endcase
        end
        1: begin
          if (pair && $urandom_range(0, 1)) second = 6'($urandom_range(total, 63));
          else first = 6'($urandom_range(total, 63));
        end
        2: begin
          pair = 1'b1;
          second = first;
        end
        default: ;
      endcase
      if (total < 1 || total > 6) need = 0;
      else if (pair) need = (total >= 2) ? (1 << (total - 2)) : 1;
      else need = 1 << (total - 1);
      in_idle = $urandom_range(0, 3) != 0;
      out_idle = $urandom_range(0, 3) != 0;
      set_config(pair, first, second, total[5:0]);
      repeat ($urandom_range(1, 4)) begin
        groups = (need == 0 || $urandom_range(0, 7) == 0) ? $urandom_range(1, 4) : need;
        send_state(groups, $urandom_range(0, 9));
      end
    end
  endtask

  initial begin : main_sequence
    int waited;
    clk = 1'b0;
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    in_amp0_real = '0;
    in_amp0_imag = '0;
    in_amp1_real = '0;
    in_amp1_imag = '0;
    in_amp2_real = '0;
    in_amp2_imag = '0;
    in_amp3_real = '0;
    in_amp3_imag = '0;
    in_group_last = 1'b0;
    in_idle = 1'b1;
    out_idle = 1'b1;
    hold_cycles = 0;
    groups_sent = 0;
    matrices_seen = 0;
    entries_checked = 0;
    mismatches = 0;
    cfg_pair = 1'b1;
    cfg_first = 6'd0;
    cfg_second = 6'd1;
    cfg_total = 6'd2;
    clear_accumulators();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_single_qubit();
    test_status_codes();
    test_output_backpressure();
    test_random_states(430);

    in_valid <= 1'b0;
    waited = 0;
    while (pending_entries.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (30) @(posedge clk);
    if (pending_entries.size() != 0)
      report_mismatch("results never delivered", 0, pending_entries.size());
    $display("Summary: %0d groups sent, %0d matrices or errors predicted, %0d entries checked.",
             groups_sent, matrices_seen, entries_checked);
    $display("Covered both modes, every status code, extreme amplitudes and long output stalls.");
    if (mismatches == 0) begin
      $display("reduced_density_matrix_accumulator_top test passed");
    end else begin
      $display("reduced_density_matrix_accumulator_top test failed");
    end
    $finish;
  end

  initial begin : watchdog
    #(64'd8 * 64'd1500000);
    $display("reduced_density_matrix_accumulator_top test failed");
    $finish;
  end

endmodule
